// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk_sig, rstn_sig, ante, cons, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk_sig, rstn_sig, ante, cons, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/plks_pkg.sv =====
// Shared constants, types and codes of the positional record list.
`default_nettype none

package plks_pkg;

    // Storage shape
    localparam int DEPTH    = 64;
    localparam int KEY_BITS = 64;

    // Fixed port widths
    localparam int PORT_KEY_W = 64;
    localparam int PORT_POS_W = 7;
    localparam int PORT_CNT_W = 7;
    localparam int MODE_W     = 3;

    // Internal widths
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = ((CNT_W > PORT_POS_W) ? CNT_W : PORT_POS_W) + 1;

    typedef logic [KEY_BITS-1:0] key_t;
    typedef key_t [DEPTH-1:0]    key_row_t;
    typedef logic [CNT_W-1:0]    count_t;
    typedef logic [POS_W-1:0]    pos_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT    = 3'd0,
        MODE_REMOVE    = 3'd1,
        MODE_FIND_ID   = 3'd2,
        MODE_FIND_NAME = 3'd3,
        MODE_COUNT     = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } state_t;

    // Per-cell shift and compare control
    typedef struct packed {
        logic take_left;
        logic take_new;
        logic take_right;
        logic cmp_id;
        logic cmp_name;
    } cell_ctrl_t;

    // First-match result from the match unit
    typedef struct packed {
        logic found;
        pos_t position;
        key_t id;
        key_t name;
    } match_t;

endpackage

`default_nettype wire

// ===== rtl/core/plks_if.sv =====
// Valid/ready channel interfaces for commands and responses.
`default_nettype none

interface plks_in_if;
    logic                              valid;
    logic                              ready;
    logic [plks_pkg::MODE_W-1:0]       mode;
    logic [plks_pkg::PORT_POS_W-1:0]   position;
    logic [plks_pkg::PORT_KEY_W-1:0]   id_key;
    logic [plks_pkg::PORT_KEY_W-1:0]   name_key;

    modport source (output valid, mode, position, id_key, name_key, input ready);
    modport sink   (input valid, mode, position, id_key, name_key, output ready);
endinterface

interface plks_out_if;
    logic                              valid;
    logic                              ready;
    logic                              status;
    logic [plks_pkg::PORT_POS_W-1:0]   found_position;
    logic [plks_pkg::PORT_KEY_W-1:0]   found_id;
    logic [plks_pkg::PORT_KEY_W-1:0]   found_name;
    logic [plks_pkg::PORT_CNT_W-1:0]   entry_count;

    modport source (output valid, status, found_position, found_id, found_name, entry_count,
                    input ready);
    modport sink   (input valid, status, found_position, found_id, found_name, entry_count,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/plks_cell.sv =====
// One list cell: holds a record, shifts with its neighbors, compares a key.
`default_nettype none

module plks_cell (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire plks_pkg::cell_ctrl_t ctrl,
    input  wire plks_pkg::key_t       cmd_id,
    input  wire plks_pkg::key_t       cmd_name,
    input  wire plks_pkg::key_t       left_id,
    input  wire plks_pkg::key_t       left_name,
    input  wire plks_pkg::key_t       right_id,
    input  wire plks_pkg::key_t       right_name,
    output plks_pkg::key_t            id,
    output plks_pkg::key_t            name,
    output logic                      hit
);

    plks_pkg::key_t id_reg;
    plks_pkg::key_t id_next;
    plks_pkg::key_t name_reg;
    plks_pkg::key_t name_next;
    logic           hit_reg;
    logic           hit_next;

    // Select new record, shift up from the left, or close the gap from the right
    always_comb
    begin
        id_next   = id_reg;
        name_next = name_reg;
        priority if (ctrl.take_new)
        begin
            id_next   = cmd_id;
            name_next = cmd_name;
        end
        else if (ctrl.take_left)
        begin
            id_next   = left_id;
            name_next = left_name;
        end
        else if (ctrl.take_right)
        begin
            id_next   = right_id;
            name_next = right_name;
        end
    end

    // Compare the held record against the search key
    always_comb
    begin
        hit_next = (ctrl.cmp_id && (id_reg == cmd_id))
                || (ctrl.cmp_name && (name_reg == cmd_name));
    end

    // Hold record data
    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        name_reg <= name_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign id   = id_reg;
    assign name = name_reg;
    assign hit  = hit_reg;

endmodule

`default_nettype wire

// ===== rtl/core/plks_match.sv =====
// First-match select: isolates the lowest hit and gathers its record and position.
`default_nettype none

module plks_match (
    input  wire logic [plks_pkg::DEPTH-1:0] hits,
    input  wire plks_pkg::key_row_t         ids,
    input  wire plks_pkg::key_row_t         names,
    output plks_pkg::match_t                result
);

    logic [plks_pkg::DEPTH-1:0] first;

    // Isolate the lowest set hit bit
    assign first = hits & (~hits + plks_pkg::DEPTH'(1));

    // Gather the selected record with a one-hot AND-OR
    always_comb
    begin
        plks_pkg::pos_t pos_acc;
        plks_pkg::key_t id_acc;
        plks_pkg::key_t name_acc;
        pos_acc  = '0;
        id_acc   = '0;
        name_acc = '0;
        for (int i = 0; i < plks_pkg::DEPTH; i++)
        begin
            if (first[i])
            begin
                pos_acc  = pos_acc | plks_pkg::pos_t'(i + 1);
                id_acc   = id_acc | ids[i];
                name_acc = name_acc | names[i];
            end
        end
        result.found    = |hits;
        result.position = pos_acc;
        result.id       = id_acc;
        result.name     = name_acc;
    end

endmodule

`default_nettype wire

// ===== rtl/core/positional_list_with_key_search.sv =====
// Top level of the positional record list with key search.
//
//   channel | dir | contents
//   --------+-----+---------------------------------------------------------
//   cmd     | in  | mode, position, id_key, name_key
//   rsp     | out | status, found_position, found_id, found_name, entry_count
//
// A transaction is registered at accept and executed in the cell row in the next
// cycle; its response is then loaded into the output register once that register
// is free. The next command is taken in that load cycle, so no command is accepted
// while another is executing.
// Reset clears the record count and control; record contents are not cleared.
// A stalled response holds the block in the load cycle and keeps cmd.ready low.
`default_nettype none

module positional_list_with_key_search (
    input  wire logic  clk,
    input  wire logic  rst_n,
    plks_in_if.sink    cmd,
    plks_out_if.source rsp
);

    // Control
    plks_pkg::state_t state_reg;
    plks_pkg::state_t state_next;
    logic             exec_en;
    logic             done_load;
    logic             rsp_free;
    logic             cmd_take;

    // Registered command
    plks_pkg::mode_t                  mode_reg;
    logic [plks_pkg::PORT_POS_W-1:0]  pos_reg;
    plks_pkg::key_t                   key_id_reg;
    plks_pkg::key_t                   key_name_reg;

    // List state
    plks_pkg::count_t count_reg;
    plks_pkg::count_t count_next;
    logic             status_reg;
    logic             status_next;

    // Execute decisions
    plks_pkg::pos_t pos_w;
    plks_pkg::pos_t cnt_w;
    logic           ins_ok;
    logic           rem_ok;
    logic           is_find;

    // Cell row
    plks_pkg::key_row_t         cell_id;
    plks_pkg::key_row_t         cell_name;
    logic [plks_pkg::DEPTH-1:0] cell_hit;
    plks_pkg::match_t           match;

    // Response register
    logic                            rsp_valid_reg;
    logic                            rsp_status_reg;
    logic [plks_pkg::PORT_POS_W-1:0] rsp_pos_reg;
    logic [plks_pkg::PORT_KEY_W-1:0] rsp_id_reg;
    logic [plks_pkg::PORT_KEY_W-1:0] rsp_name_reg;
    logic [plks_pkg::PORT_CNT_W-1:0] rsp_count_reg;

    assign rsp_free = !rsp_valid_reg || rsp.ready;
    assign cmd_take = cmd.valid && cmd.ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            plks_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = plks_pkg::ST_EXEC;
                end
            end
            plks_pkg::ST_EXEC:
            begin
                state_next = plks_pkg::ST_DONE;
            end
            plks_pkg::ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = cmd.valid ? plks_pkg::ST_EXEC : plks_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = plks_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        cmd.ready = 1'b0;
        exec_en   = 1'b0;
        done_load = 1'b0;
        unique case (state_reg)
            plks_pkg::ST_IDLE:
            begin
                cmd.ready = 1'b1;
            end
            plks_pkg::ST_EXEC:
            begin
                exec_en = 1'b1;
            end
            plks_pkg::ST_DONE:
            begin
                cmd.ready = rsp_free;
                done_load = rsp_free;
            end
            default:
            begin
                cmd.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plks_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Capture the command transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= plks_pkg::MODE_COUNT;
        end
        else if (cmd_take)
        begin
            mode_reg <= plks_pkg::mode_t'(cmd.mode);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            pos_reg      <= cmd.position;
            key_id_reg   <= plks_pkg::KEY_BITS'(cmd.id_key);
            key_name_reg <= plks_pkg::KEY_BITS'(cmd.name_key);
        end
    end

    // Validate insert and remove against the current count
    assign pos_w   = plks_pkg::pos_t'(pos_reg);
    assign cnt_w   = plks_pkg::pos_t'(count_reg);
    assign ins_ok  = (mode_reg == plks_pkg::MODE_INSERT)
                  && (count_reg < plks_pkg::CNT_W'(plks_pkg::DEPTH))
                  && (pos_w != '0) && (pos_w <= cnt_w + plks_pkg::pos_t'(1));
    assign rem_ok  = (mode_reg == plks_pkg::MODE_REMOVE)
                  && (pos_w != '0) && (pos_w <= cnt_w);
    assign is_find = (mode_reg == plks_pkg::MODE_FIND_ID)
                  || (mode_reg == plks_pkg::MODE_FIND_NAME);

    // Update count and command status at the end of execute
    always_comb
    begin
        count_next  = count_reg;
        status_next = 1'b1;
        unique case (mode_reg)
            plks_pkg::MODE_INSERT:
            begin
                status_next = !ins_ok;
                if (ins_ok)
                begin
                    count_next = count_reg + plks_pkg::count_t'(1);
                end
            end
            plks_pkg::MODE_REMOVE:
            begin
                status_next = !rem_ok;
                if (rem_ok)
                begin
                    count_next = count_reg - plks_pkg::count_t'(1);
                end
            end
            plks_pkg::MODE_COUNT:
            begin
                status_next = 1'b0;
            end
            default:
            begin
                status_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            status_reg <= 1'b1;
        end
        else if (exec_en)
        begin
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    // Cell row with per-cell shift and compare control
    // Compares stay enabled while a find command is held, so a stalled response keeps its hits
    for (genvar g = 0; g < plks_pkg::DEPTH; g++)
    begin : g_cell
        localparam plks_pkg::pos_t CELL_POS = plks_pkg::pos_t'(g + 1);

        plks_pkg::cell_ctrl_t ctrl;
        plks_pkg::key_t       left_id;
        plks_pkg::key_t       left_name;
        plks_pkg::key_t       right_id;
        plks_pkg::key_t       right_name;
        logic                 occupied;

        assign occupied        = CELL_POS <= cnt_w;
        assign ctrl.take_left  = exec_en && ins_ok && (CELL_POS > pos_w);
        assign ctrl.take_new   = exec_en && ins_ok && (CELL_POS == pos_w);
        assign ctrl.take_right = exec_en && rem_ok && (CELL_POS >= pos_w);
        assign ctrl.cmp_id     = occupied && (mode_reg == plks_pkg::MODE_FIND_ID);
        assign ctrl.cmp_name   = occupied && (mode_reg == plks_pkg::MODE_FIND_NAME);

        if (g == 0)
        begin : g_first
            assign left_id   = key_id_reg;
            assign left_name = key_name_reg;
        end
        else
        begin : g_inner_left
            assign left_id   = cell_id[g-1];
            assign left_name = cell_name[g-1];
        end

        if (g == plks_pkg::DEPTH - 1)
        begin : g_last
            assign right_id   = cell_id[g];
            assign right_name = cell_name[g];
        end
        else
        begin : g_inner_right
            assign right_id   = cell_id[g+1];
            assign right_name = cell_name[g+1];
        end

        plks_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .cmd_id     (key_id_reg),
            .cmd_name   (key_name_reg),
            .left_id    (left_id),
            .left_name  (left_name),
            .right_id   (right_id),
            .right_name (right_name),
            .id         (cell_id[g]),
            .name       (cell_name[g]),
            .hit        (cell_hit[g])
        );
    end

    plks_match u_match (
        .hits   (cell_hit),
        .ids    (cell_id),
        .names  (cell_name),
        .result (match)
    );

    // Load the response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (done_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_load)
        begin
            rsp_status_reg <= is_find ? !match.found : status_reg;
            rsp_pos_reg    <= plks_pkg::PORT_POS_W'(match.position);
            rsp_id_reg     <= plks_pkg::PORT_KEY_W'(match.id);
            rsp_name_reg   <= plks_pkg::PORT_KEY_W'(match.name);
            rsp_count_reg  <= plks_pkg::PORT_CNT_W'(count_reg);
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = rsp_status_reg;
    assign rsp.found_position = rsp_pos_reg;
    assign rsp.found_id       = rsp_id_reg;
    assign rsp.found_name     = rsp_name_reg;
    assign rsp.entry_count    = rsp_count_reg;

endmodule

`default_nettype wire

// ===== rtl/core/plks_checker.sv =====
// Port-level checker for the positional record list, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module plks_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            cmd_valid,
    input wire logic                            cmd_ready,
    input wire logic                            rsp_valid,
    input wire logic                            rsp_ready,
    input wire logic                            rsp_status,
    input wire logic [plks_pkg::PORT_POS_W-1:0] rsp_found_position,
    input wire logic [plks_pkg::PORT_KEY_W-1:0] rsp_found_id,
    input wire logic [plks_pkg::PORT_KEY_W-1:0] rsp_found_name,
    input wire logic [plks_pkg::PORT_CNT_W-1:0] rsp_entry_count
);

    // Drop ready in the cycle after a command transaction
    `ASSERT_NEXT(a_cmd_gap, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready, "ready after accept")

    // Failed responses carry no record
    `ASSERT_IMPL(a_fail_zero, clk, rst_n, rsp_valid && rsp_status, (rsp_found_position == '0) && (rsp_found_id == '0) && (rsp_found_name == '0), "failure with record data")

    // A found position is a success within the held records
    `ASSERT_IMPL(a_pos_range, clk, rst_n, rsp_valid && (rsp_found_position != '0), !rsp_status && (rsp_found_position <= rsp_entry_count), "found position out of range")

    // Count never exceeds the list capacity
    `ASSERT_IMPL(a_count_cap, clk, rst_n, rsp_valid, rsp_entry_count <= plks_pkg::DEPTH, "count above capacity")

    // Hold a stalled response
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_found_id) && $stable(rsp_entry_count), "stalled response changed")

endmodule

bind positional_list_with_key_search plks_checker u_plks_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_valid          (cmd.valid),
    .cmd_ready          (cmd.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_status         (rsp.status),
    .rsp_found_position (rsp.found_position),
    .rsp_found_id       (rsp.found_id),
    .rsp_found_name     (rsp.found_name),
    .rsp_entry_count    (rsp.entry_count)
);

`default_nettype wire

// ===== verif/positional_list_with_key_search_tb.sv =====
// Self-checking testbench for the positional record list with key search.
module positional_list_with_key_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import plks_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 325;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 8;

    // Modes outside the defined command set
    localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0]     mode;
        logic [PORT_POS_W-1:0] position;
        logic [PORT_KEY_W-1:0] id_key;
        logic [PORT_KEY_W-1:0] name_key;
    } list_cmd_t;

    typedef struct packed {
        logic                  status;
        logic [PORT_POS_W-1:0] found_position;
        logic [PORT_KEY_W-1:0] found_id;
        logic [PORT_KEY_W-1:0] found_name;
        logic [PORT_CNT_W-1:0] entry_count;
    } list_rsp_t;

    typedef struct {
        list_cmd_t cmd;
        bit        fixed;
        list_rsp_t rsp;
    } plan_row_t;

    logic clk;
    logic rst_n;

    plks_in_if  cmd_if ();
    plks_out_if rsp_if ();

    positional_list_with_key_search u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    // Shadow copy of the record list
    key_t rec_id   [DEPTH];
    key_t rec_name [DEPTH];
    int   rec_count;

    list_rsp_t pending_rsp [$];
    plan_row_t plan [$];

    int mismatches;
    int rsp_seen;
    int burst_left;
    int cycle_count;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Stop a hung run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Apply one command to the shadow list and return the response it yields
    function automatic list_rsp_t apply_list_cmd(input list_cmd_t c);
        list_rsp_t r;
        key_t      idk;
        key_t      nmk;
        int        p;
        int        i;
        bit        hit;
        r         = '0;
        r.status  = STATUS_ERR;
        idk       = key_t'(c.id_key);
        nmk       = key_t'(c.name_key);
        p         = c.position;
        hit       = 1'b0;
        case (c.mode)
            MODE_INSERT:
            begin
                if (rec_count < DEPTH && p >= 1 && p <= rec_count + 1)
                begin
                    for (i = rec_count; i > p - 1; i--)
                    begin
                        rec_id[i]   = rec_id[i-1];
                        rec_name[i] = rec_name[i-1];
                    end
                    rec_id[p-1]   = idk;
                    rec_name[p-1] = nmk;
                    rec_count++;
                    r.status = STATUS_OK;
                end
            end
            MODE_REMOVE:
            begin
                if (p >= 1 && p <= rec_count)
                begin
                    for (i = p - 1; i + 1 < rec_count; i++)
                    begin
                        rec_id[i]   = rec_id[i+1];
                        rec_name[i] = rec_name[i+1];
                    end
                    rec_count--;
                    r.status = STATUS_OK;
                end
            end
            MODE_FIND_ID, MODE_FIND_NAME:
            begin
                // first match wins, lowest position first
                for (i = 0; i < rec_count && !hit; i++)
                begin
                    if ((c.mode == MODE_FIND_ID) ? (rec_id[i] == idk) : (rec_name[i] == nmk))
                    begin
                        hit              = 1'b1;
                        r.status         = STATUS_OK;
                        r.found_position = PORT_POS_W'(i + 1);
                        r.found_id       = rec_id[i];
                        r.found_name     = rec_name[i];
                    end
                end
            end
            MODE_COUNT:
                r.status = STATUS_OK;
            default:
                r.status = STATUS_ERR;
        endcase
        r.entry_count = PORT_CNT_W'(rec_count);
        return r;
    endfunction

    function automatic logic [PORT_KEY_W-1:0] rand_key();
        case ($urandom_range(0, 5))
            0:       return PORT_KEY_W'($urandom_range(0, 7));
            1:       return '1;
            2:       return '0;
            3:       return 64'h1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Build a mostly well-formed command that steers the list toward a fill level
    function automatic list_cmd_t rand_cmd(input int target);
        list_cmd_t c;
        int        r;
        bit        grow;
        c.id_key   = rand_key();
        c.name_key = rand_key();
        c.position = PORT_POS_W'($urandom_range(0, 127));
        r          = $urandom_range(0, 99);
        grow       = (rec_count < target) || (target == DEPTH);
        if (r < 40)
        begin
            if (grow ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 9) < 2))
            begin
                c.mode     = MODE_INSERT;
                c.position = PORT_POS_W'($urandom_range(1, rec_count + 1));
            end
            else
            begin
                c.mode     = MODE_REMOVE;
                c.position = PORT_POS_W'((rec_count > 0) ? $urandom_range(1, rec_count) : 1);
            end
        end
        else if (r < 80)
        begin
            c.mode = (r < 60) ? MODE_FIND_ID : MODE_FIND_NAME;
            // mostly search for keys that are present
            if (rec_count > 0 && $urandom_range(0, 9) < 7)
            begin
                c.id_key   = rec_id[$urandom_range(0, rec_count - 1)];
                c.name_key = rec_name[$urandom_range(0, rec_count - 1)];
            end
        end
        else if (r < 86)
            c.mode = MODE_COUNT;
        else if (r < 93)
            c.mode = ($urandom_range(0, 1) != 0) ? MODE_INSERT : MODE_REMOVE;
        else
            c.mode = MODE_W'($urandom_range(MODE_RSVD5, MODE_RSVD7));
        return c;
    endfunction

    task automatic add_row(input logic [MODE_W-1:0] m, input int p,
                           input logic [PORT_KEY_W-1:0] idk, input logic [PORT_KEY_W-1:0] nmk,
                           input bit fixed, input logic st, input int cnt);
        plan_row_t row;
        row.cmd.mode         = m;
        row.cmd.position     = PORT_POS_W'(p);
        row.cmd.id_key       = idk;
        row.cmd.name_key     = nmk;
        row.fixed            = fixed;
        row.rsp              = '0;
        row.rsp.status       = st;
        row.rsp.entry_count  = PORT_CNT_W'(cnt);
        plan = {plan, row};
    endtask

    // Offer one transaction after an optional gap; return at the accepting edge
    task automatic send_cmd(input list_cmd_t c, input bit fixed, input list_rsp_t fixed_rsp);
        int        gap;
        list_rsp_t pred;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        burst_left--;
        if (gap > 0)
        begin
            cmd_if.valid    <= 1'b0;
            cmd_if.mode     <= MODE_W'($urandom);
            cmd_if.position <= PORT_POS_W'($urandom);
            cmd_if.id_key   <= {$urandom, $urandom};
            cmd_if.name_key <= {$urandom, $urandom};
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid    <= 1'b1;
        cmd_if.mode     <= c.mode;
        cmd_if.position <= c.position;
        cmd_if.id_key   <= c.id_key;
        cmd_if.name_key <= c.name_key;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        pred = apply_list_cmd(c);
        pending_rsp = {pending_rsp, (fixed ? fixed_rsp : pred)};
    endtask

    // Hold off the sender until every expected response has arrived
    task automatic drain_rsp();
        cmd_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_rsp.size() != 0);
    endtask

    // Stimulus
    initial
    begin : stim
        int        ph;
        int        n;
        int        targets [5];
        list_rsp_t none;
        rst_n           <= 1'b0;
        cmd_if.valid    <= 1'b0;
        cmd_if.mode     <= MODE_COUNT;
        cmd_if.position <= '0;
        cmd_if.id_key   <= '0;
        cmd_if.name_key <= '0;
        rec_count  = 0;
        mismatches = 0;
        burst_left = 0;
        none       = '0;
        targets    = '{DEPTH, 4, 48, DEPTH, 16};

        // empty list, bad positions, extremes of keys and positions, reserved modes
        add_row(MODE_COUNT,     0,   '0, '0, 1, STATUS_OK,  0);
        add_row(MODE_FIND_ID,   0,   '0, '1, 1, STATUS_ERR, 0);
        add_row(MODE_FIND_NAME, 127, '1, '0, 1, STATUS_ERR, 0);
        add_row(MODE_REMOVE,    1,   '0, '0, 1, STATUS_ERR, 0);
        add_row(MODE_INSERT,    0,   64'h5, 64'h5, 1, STATUS_ERR, 0);
        add_row(MODE_INSERT,    2,   64'h6, 64'h6, 1, STATUS_ERR, 0);
        add_row(MODE_INSERT,    1,   '1, '0, 1, STATUS_OK,  1);
        add_row(MODE_INSERT,    1,   '0, '1, 1, STATUS_OK,  2);
        add_row(MODE_INSERT,    3,   64'h0123_4567_89ab_cdef, 64'ha5a5_5a5a_a5a5_5a5a,
                0, STATUS_OK, 0);
        add_row(MODE_FIND_ID,   127, '0, 64'h7, 0, STATUS_OK, 0);
        add_row(MODE_FIND_NAME, 0,   64'h7, '1, 0, STATUS_OK, 0);
        add_row(MODE_FIND_ID,   5,   '1, '0, 0, STATUS_OK, 0);
        add_row(MODE_FIND_NAME, 64,  '0, 64'ha5a5_5a5a_a5a5_5a5a, 0, STATUS_OK, 0);
        add_row(MODE_FIND_ID,   0,   64'hdead_beef, '0, 0, STATUS_OK, 0);
        add_row(MODE_RSVD5,     1,   '0, '0, 1, STATUS_ERR, 3);
        add_row(MODE_RSVD6,     2,   '1, '0, 1, STATUS_ERR, 3);
        add_row(MODE_RSVD7,     127, '1, '1, 1, STATUS_ERR, 3);
        add_row(MODE_REMOVE,    4,   '0, '0, 1, STATUS_ERR, 3);
        add_row(MODE_REMOVE,    127, '0, '0, 1, STATUS_ERR, 3);
        add_row(MODE_INSERT,    64,  '1, '1, 1, STATUS_ERR, 3);
        add_row(MODE_REMOVE,    2,   '0, '0, 0, STATUS_OK, 0);
        add_row(MODE_FIND_ID,   0,   '1, '0, 0, STATUS_OK, 0);
        add_row(MODE_REMOVE,    2,   '0, '0, 0, STATUS_OK, 0);
        add_row(MODE_REMOVE,    1,   '0, '0, 0, STATUS_OK, 0);
        add_row(MODE_COUNT,     0,   '1, '1, 1, STATUS_OK, 0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        foreach (plan[k])
            send_cmd(plan[k].cmd, plan[k].fixed, plan[k].rsp);
        drain_rsp();

        // random phases, each steering toward its own fill level
        for (ph = 0; ph < 5; ph++)
        begin
            for (n = 0; n < PHASE_ITEMS; n++)
                send_cmd(rand_cmd(targets[ph]), 1'b0, none);
            if (ph == 2)
                drain_rsp();
        end

        drain_rsp();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    task automatic cmp_field(input string fld, input logic [PORT_KEY_W-1:0] want,
                             input logic [PORT_KEY_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, fld, want, got);
            mismatches++;
        end
    endtask

    // Response sink: check each transaction and stall on a pattern of its own
    initial
    begin : rsp_sink
        logic [15:0] stall_pat;
        int          pat_left;
        int          hold_left;
        bit          hold_done;
        list_rsp_t   want;
        rsp_if.ready <= 1'b0;
        stall_pat = '0;
        pat_left  = 0;
        hold_left = 0;
        hold_done = 1'b0;
        rsp_seen  = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
            begin
                rsp_seen++;
                if (pending_rsp.size() == 0)
                begin
                    $display("%0t ns: unexpected response, expected none, actual %0h/%0h",
                             $time, rsp_if.status, rsp_if.entry_count);
                    mismatches++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    cmp_field("status",         want.status,         rsp_if.status);
                    cmp_field("found_position", want.found_position, rsp_if.found_position);
                    cmp_field("found_id",       want.found_id,       rsp_if.found_id);
                    cmp_field("found_name",     want.found_name,     rsp_if.found_name);
                    cmp_field("entry_count",    want.entry_count,    rsp_if.entry_count);
                end
            end

            // long hold-off once, so the block backs up into its input
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (!hold_done && rsp_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                if (pat_left == 0)
                begin
                    pat_left = $urandom_range(16, 96);
                    case ($urandom_range(0, 3))
                        0:       stall_pat = '0;
                        1:       stall_pat = 16'($urandom);
                        2:       stall_pat = 16'($urandom) & 16'($urandom);
                        default: stall_pat = 16'hfffe;
                    endcase
                end
                pat_left--;
                rsp_if.ready <= ~stall_pat[0];
                stall_pat = {stall_pat[0], stall_pat[15:1]};
            end
        end
    end

endmodule
